@@ src/rrts_pkg.sv @@
package rrts_pkg;

  localparam int unsigned TaskSlotsDef = 8;
  localparam int unsigned IdW          = 32;
  localparam int unsigned TickW        = 32;
  localparam int unsigned OpW          = 3;
  localparam int unsigned OutIdxW      = 3;
  localparam int unsigned OutCntW      = 4;
  localparam int unsigned OutDataW     = 48;

  typedef enum logic [OpW-1:0] {
    OP_CREATE  = 3'd0,
    OP_DISABLE = 3'd1,
    OP_ENABLE  = 3'd2,
    OP_TICK    = 3'd3,
    OP_SWITCH  = 3'd4,
    OP_START   = 3'd5,
    OP_BLOCK   = 3'd6,
    OP_RESUME  = 3'd7
  } op_e;

  typedef enum logic [1:0] {
    TS_DORMANT = 2'd0,
    TS_READY   = 2'd1,
    TS_EXEC    = 2'd2,
    TS_BLOCKED = 2'd3
  } task_state_e;

  // flags from the shared step unit
  typedef struct packed {
    logic ready_hit;  // entry after the cursor is ready
    logic id_hit;     // identifier read back matches the key
    logic wrap;       // cursor wrapped to entry 0
  } step_flags_t;

endpackage

@@ src/rrts_id_ram.sv @@
module rrts_id_ram #(
  parameter int unsigned TASK_SLOTS = rrts_pkg::TaskSlotsDef
) (
  input  logic                                 clk_i,
  input  logic                                 wr_en_i,
  input  logic [$clog2(TASK_SLOTS)-1:0]        wr_addr_i,
  input  logic [rrts_pkg::IdW-1:0]             wr_data_i,
  input  logic                                 rd_en_i,
  input  logic [$clog2(TASK_SLOTS)-1:0]        rd_addr_i,
  output logic [rrts_pkg::IdW-1:0]             rd_data_o
);
  import rrts_pkg::*;

  logic [IdW-1:0] mem_q [TASK_SLOTS];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_o <= mem_q[rd_addr_i];
    end
  end

endmodule

@@ src/rrts_step_unit.sv @@
module rrts_step_unit #(
  parameter int unsigned TASK_SLOTS = rrts_pkg::TaskSlotsDef
) (
  input  logic [$clog2(TASK_SLOTS)-1:0]   cursor_i,
  input  logic [$clog2(TASK_SLOTS+1)-1:0] count_i,
  output logic [$clog2(TASK_SLOTS)-1:0]   next_o,
  input  rrts_pkg::task_state_e           next_state_i,
  input  logic [rrts_pkg::IdW-1:0]        rd_id_i,
  input  logic [rrts_pkg::IdW-1:0]        key_i,
  output rrts_pkg::step_flags_t           flags_o
);
  import rrts_pkg::*;

  localparam int unsigned IdxW = $clog2(TASK_SLOTS);
  localparam int unsigned CntW = $clog2(TASK_SLOTS + 1);

  logic [CntW-1:0] inc;

  // cyclic increment modulo the fill count
  assign inc               = CntW'(cursor_i) + CntW'(1);
  assign flags_o.wrap      = (inc == count_i);
  assign next_o            = flags_o.wrap ? '0 : inc[IdxW-1:0];
  assign flags_o.ready_hit = (next_state_i == TS_READY);
  assign flags_o.id_hit    = (rd_id_i == key_i);

endmodule

@@ src/round_robin_task_scheduler.sv @@
// Round-robin task scheduler. Holds up to TASK_SLOTS tasks (identifier plus a
// dormant/ready/executing/blocked state) and takes one command beat at a time
// on the slave stream: tuser carries the op (create, disable, enable, tick,
// switch, start, block, resume), tdata the task identifier. Every command
// returns exactly one status beat on the master stream showing the state after
// the op: chosen and running task index with valid flags, the tick count, the
// number of created tasks and a table-full flag for a create that was refused.
// Create, switch, block and resume go from accept straight to the result
// state. Tick and start walk the table one entry per cycle through a shared
// increment/compare unit, at most one lap over the N created tasks (a hit
// ends the walk early). Disable and enable scan the identifier RAM, whose
// read is registered, over the created entries. The block accepts
// one command at a time; the result sits in an output register, so the next
// command may be taken while the previous status beat still waits.
module round_robin_task_scheduler #(
  parameter int unsigned TASK_SLOTS = rrts_pkg::TaskSlotsDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // command stream
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [rrts_pkg::IdW-1:0]      s_axis_tdata,   // [31:0] task_id
  input  logic [rrts_pkg::OpW-1:0]      s_axis_tuser,   // [2:0] op
  // status stream
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // [2:0] chosen_index, [3] chosen_valid, [6:4] running_index,
  // [7] running_valid, [39:8] tick_total, [43:40] task_total,
  // [44] table_full_error, [47:45] zero
  output logic [rrts_pkg::OutDataW-1:0] m_axis_tdata
);
  import rrts_pkg::*;

  localparam int unsigned IdxW = $clog2(TASK_SLOTS);
  localparam int unsigned CntW = $clog2(TASK_SLOTS + 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_MATCH,
    ST_DONE
  } fsm_e;

  fsm_e            state_q, state_d;
  op_e             op_q, op_d;
  logic [IdW-1:0]  key_q, key_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [IdxW-1:0] cur_q, cur_d;
  logic            run_vld_q, run_vld_d;
  logic [IdxW-1:0] run_idx_q, run_idx_d;
  logic            pick_vld_q, pick_vld_d;
  logic [IdxW-1:0] pick_idx_q, pick_idx_d;
  logic [TickW-1:0] tick_q, tick_d;
  logic            full_q, full_d;
  logic [CntW-1:0] left_q, left_d;    // walk steps remaining
  logic [CntW-1:0] scan_q, scan_d;    // next RAM address to read
  logic            cmp_vld_q, cmp_vld_d;
  logic [IdxW-1:0] cmp_idx_q, cmp_idx_d;
  task_state_e     ent_q [TASK_SLOTS];
  task_state_e     ent_d [TASK_SLOTS];
  logic            out_vld_q, out_vld_d;
  logic [OutDataW-1:0] out_data_q, out_data_d;

  logic            accept;
  op_e             op_in;
  logic            table_full;
  logic [IdxW-1:0] nxt;
  step_flags_t     flags;
  logic            ram_wr;
  logic            ram_rd;
  logic [IdW-1:0]  ram_rdata;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign op_in         = op_e'(s_axis_tuser);
  assign table_full    = (cnt_q == CntW'(TASK_SLOTS));
  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_data_q;

  // identifier store: appended on create, scanned in order on disable/enable
  assign ram_wr = accept && (op_in == OP_CREATE) && !table_full;
  assign ram_rd = (state_q == ST_MATCH) && !(cmp_vld_q && flags.id_hit) &&
                  (scan_q != cnt_q);

  rrts_id_ram #(
    .TASK_SLOTS(TASK_SLOTS)
  ) u_id_ram (
    .clk_i    (clk_i),
    .wr_en_i  (ram_wr),
    .wr_addr_i(cnt_q[IdxW-1:0]),
    .wr_data_i(s_axis_tdata),
    .rd_en_i  (ram_rd),
    .rd_addr_i(scan_q[IdxW-1:0]),
    .rd_data_o(ram_rdata)
  );

  // shared unit: cursor step modulo count, ready test and identifier compare
  rrts_step_unit #(
    .TASK_SLOTS(TASK_SLOTS)
  ) u_step (
    .cursor_i    (cur_q),
    .count_i     (cnt_q),
    .next_o      (nxt),
    .next_state_i(ent_q[nxt]),
    .rd_id_i     (ram_rdata),
    .key_i       (key_q),
    .flags_o     (flags)
  );

  always_comb begin
    state_d    = state_q;
    op_d       = op_q;
    key_d      = key_q;
    cnt_d      = cnt_q;
    cur_d      = cur_q;
    run_vld_d  = run_vld_q;
    run_idx_d  = run_idx_q;
    pick_vld_d = pick_vld_q;
    pick_idx_d = pick_idx_q;
    tick_d     = tick_q;
    full_d     = full_q;
    left_d     = left_q;
    scan_d     = scan_q;
    cmp_vld_d  = cmp_vld_q;
    cmp_idx_d  = cmp_idx_q;
    ent_d      = ent_q;
    out_data_d = out_data_q;
    out_vld_d  = out_vld_q && !m_axis_tready;

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          op_d    = op_in;
          key_d   = s_axis_tdata;
          full_d  = 1'b0;
          state_d = ST_DONE;
          case (op_in)
            OP_CREATE: begin
              if (table_full) begin
                full_d = 1'b1;
              end else begin
                ent_d[cnt_q[IdxW-1:0]] = TS_READY;
                cnt_d = cnt_q + CntW'(1);
                cur_d = cnt_q[IdxW-1:0];
              end
            end
            OP_DISABLE, OP_ENABLE: begin
              scan_d    = '0;
              cmp_vld_d = 1'b0;
              state_d   = ST_MATCH;
            end
            OP_TICK, OP_START: begin
              if (op_in == OP_TICK) begin
                tick_d = tick_q + TickW'(1);
              end
              if (cnt_q == '0) begin
                // empty table: the running task stays chosen
                pick_vld_d = run_vld_q;
                pick_idx_d = run_idx_q;
              end else begin
                left_d  = cnt_q;
                state_d = ST_SEARCH;
              end
            end
            OP_SWITCH: begin
              if (pick_vld_q) begin
                if (run_vld_q) begin
                  ent_d[run_idx_q] = TS_READY;
                end
                ent_d[pick_idx_q] = TS_READY;
                run_vld_d = 1'b1;
                run_idx_d = pick_idx_q;
              end
            end
            OP_BLOCK: begin
              if (run_vld_q) begin
                ent_d[run_idx_q] = TS_BLOCKED;
              end
            end
            OP_RESUME: begin
              if (run_vld_q) begin
                ent_d[run_idx_q] = TS_EXEC;
              end
            end
            default: begin
              state_d = ST_DONE;
            end
          endcase
        end
      end

      ST_SEARCH: begin
        cur_d = nxt;
        if (flags.ready_hit) begin
          pick_vld_d = 1'b1;
          pick_idx_d = nxt;
          if (op_q == OP_START) begin
            run_vld_d = 1'b1;
            run_idx_d = nxt;
          end
          state_d = ST_DONE;
        end else if (left_q == CntW'(1)) begin
          // full lap without a ready entry
          pick_vld_d = run_vld_q;
          pick_idx_d = run_idx_q;
          state_d    = ST_DONE;
        end else begin
          left_d = left_q - CntW'(1);
        end
      end

      ST_MATCH: begin
        if (cmp_vld_q && flags.id_hit) begin
          ent_d[cmp_idx_q] = (op_q == OP_DISABLE) ? TS_DORMANT : TS_READY;
          state_d = ST_DONE;
        end else if (scan_q == cnt_q) begin
          state_d = ST_DONE;
        end else begin
          cmp_vld_d = 1'b1;
          cmp_idx_d = scan_q[IdxW-1:0];
          scan_d    = scan_q + CntW'(1);
        end
      end

      ST_DONE: begin
        if (!out_vld_q || m_axis_tready) begin
          out_vld_d  = 1'b1;
          out_data_d = {3'b000,
                        full_q,
                        OutCntW'(cnt_q),
                        tick_q,
                        run_vld_q,
                        run_vld_q ? OutIdxW'(run_idx_q) : OutIdxW'(0),
                        pick_vld_q,
                        pick_vld_q ? OutIdxW'(pick_idx_q) : OutIdxW'(0)};
          state_d    = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      op_q       <= OP_CREATE;
      cnt_q      <= '0;
      cur_q      <= '0;
      run_vld_q  <= 1'b0;
      run_idx_q  <= '0;
      pick_vld_q <= 1'b0;
      pick_idx_q <= '0;
      tick_q     <= '0;
      full_q     <= 1'b0;
      left_q     <= '0;
      scan_q     <= '0;
      cmp_vld_q  <= 1'b0;
      cmp_idx_q  <= '0;
      out_vld_q  <= 1'b0;
      for (int i = 0; i < TASK_SLOTS; i++) begin
        ent_q[i] <= TS_DORMANT;
      end
    end else begin
      state_q    <= state_d;
      op_q       <= op_d;
      cnt_q      <= cnt_d;
      cur_q      <= cur_d;
      run_vld_q  <= run_vld_d;
      run_idx_q  <= run_idx_d;
      pick_vld_q <= pick_vld_d;
      pick_idx_q <= pick_idx_d;
      tick_q     <= tick_d;
      full_q     <= full_d;
      left_q     <= left_d;
      scan_q     <= scan_d;
      cmp_vld_q  <= cmp_vld_d;
      cmp_idx_q  <= cmp_idx_d;
      out_vld_q  <= out_vld_d;
      ent_q      <= ent_d;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk_i) begin
    key_q      <= key_d;
    out_data_q <= out_data_d;
  end

  // fill count never exceeds the table size
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(TASK_SLOTS))
    else $error("task count beyond table size");

  // search cursor stays inside the created entries
  a_cur_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q != '0) |-> (CntW'(cur_q) < cnt_q))
    else $error("cursor outside created entries");

  // chosen and running tasks always name created entries
  a_pick_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pick_vld_q |-> (CntW'(pick_idx_q) < cnt_q))
    else $error("chosen task not created");

  a_run_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    run_vld_q |-> (CntW'(run_idx_q) < cnt_q))
    else $error("running task not created");

  // a tick command advances the tick counter by exactly one
  a_tick_inc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (op_in == OP_TICK)) |=> (tick_q == $past(tick_q) + TickW'(1)))
    else $error("tick counter did not advance");

endmodule

@@ sim/tb_round_robin_task_scheduler.sv @@
// Testbench for round_robin_task_scheduler.
// Commands go in on the slave stream and status beats come out on the master
// stream. A scoreboard class holds its own copy of the task table and predicts
// the status beat for each accepted command. Each returned beat is compared
// field by field with the oldest prediction.
module tb_round_robin_task_scheduler;
  import rrts_pkg::*;

  localparam int unsigned Slots          = TaskSlotsDef;
  localparam int unsigned RandomItems    = 1080;
  localparam int unsigned QuietItems     = 150;   // tail with no idling on either side
  localparam int unsigned HoldAtItem     = 300;   // long sink hold-off starts here
  localparam int unsigned DrainAtItem    = 650;   // source pauses until all status is back
  localparam int unsigned LongHoldCycles = 80;
  localparam int unsigned SettleCycles   = 30;    // extra wait after the final drain
  localparam int unsigned WatchdogLimit  = 1000;

  logic                clk_i;
  logic                rst_ni;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [IdW-1:0]      s_axis_tdata;   // [31:0] task_id
  logic [OpW-1:0]      s_axis_tuser;   // [2:0] op
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  // [2:0] chosen_index, [3] chosen_valid, [6:4] running_index,
  // [7] running_valid, [39:8] tick_total, [43:40] task_total,
  // [44] table_full_error, [47:45] zero
  logic [OutDataW-1:0] m_axis_tdata;

  // handshakes from the command source to the status sink
  int unsigned hold_asks;
  bit          quiet_end;

  round_robin_task_scheduler #(
    .TASK_SLOTS(Slots)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  typedef struct {
    logic [OutIdxW-1:0] chosen_index;
    logic               chosen_valid;
    logic [OutIdxW-1:0] running_index;
    logic               running_valid;
    logic [TickW-1:0]   tick_total;
    logic [OutCntW-1:0] task_total;
    logic               table_full_error;
  } status_t;

  class task_table_scoreboard;
    logic [IdW-1:0] ids    [Slots];
    task_state_e    states [Slots];
    int unsigned    count;
    int unsigned    cursor;
    bit             run_ok;
    int unsigned    run_slot;
    bit             pick_ok;
    int unsigned    pick_slot;
    logic [TickW-1:0] ticks;
    status_t        pending_status [$];
    int unsigned    errors;
    int unsigned    checked;
    int unsigned    op_seen [8];

    function new();
      foreach (states[k]) begin
        states[k] = TS_DORMANT;
        ids[k]    = '0;
      end
      count = 0; cursor = 0;
      run_ok = 0; run_slot = 0;
      pick_ok = 0; pick_slot = 0;
      ticks = '0; errors = 0; checked = 0;
      foreach (op_seen[k]) op_seen[k] = 0;
    endfunction

    // cyclic walk from the entry after the cursor; falls back to the running task
    function void walk_for_ready();
      for (int unsigned i = 0; i < count; i++) begin
        cursor = (cursor + 1) % count;
        if (states[cursor] == TS_READY) begin
          pick_ok   = 1;
          pick_slot = cursor;
          return;
        end
      end
      pick_ok   = run_ok;
      pick_slot = run_slot;
    endfunction

    // first created entry with this identifier only
    function void mark_first(logic [IdW-1:0] id, task_state_e st);
      for (int unsigned i = 0; i < count; i++) begin
        if (ids[i] == id) begin
          states[i] = st;
          return;
        end
      end
    endfunction

    function void note_command(op_e op, logic [IdW-1:0] id);
      bit      refused;
      status_t s;
      refused = 0;
      op_seen[int'(op)]++;
      case (op)
        OP_CREATE: begin
          if (count >= Slots) begin
            refused = 1;
          end else begin
            ids[count]    = id;
            states[count] = TS_READY;
            count++;
            cursor = count - 1;
          end
        end
        OP_DISABLE: mark_first(id, TS_DORMANT);
        OP_ENABLE:  mark_first(id, TS_READY);
        OP_TICK: begin
          ticks++;
          walk_for_ready();
        end
        OP_SWITCH: begin
          if (pick_ok) begin
            if (run_ok) states[run_slot] = TS_READY;
            run_ok   = 1;
            run_slot = pick_slot;
            states[run_slot] = TS_READY;
          end
        end
        OP_START: begin
          walk_for_ready();
          run_ok   = pick_ok;
          run_slot = pick_slot;
        end
        OP_BLOCK: begin
          if (run_ok) states[run_slot] = TS_BLOCKED;
        end
        default: begin
          if (run_ok) states[run_slot] = TS_EXEC;
        end
      endcase
      s.chosen_index     = pick_ok ? pick_slot[OutIdxW-1:0] : '0;
      s.chosen_valid     = pick_ok;
      s.running_index    = run_ok ? run_slot[OutIdxW-1:0] : '0;
      s.running_valid    = run_ok;
      s.tick_total       = ticks;
      s.task_total       = count[OutCntW-1:0];
      s.table_full_error = refused;
      pending_status.push_back(s);
    endfunction

    task report_mismatch(string what, logic [OutDataW-1:0] got, logic [OutDataW-1:0] want);
      $display("MISMATCH beat %0d: %s got 0x%0h want 0x%0h", checked, what, got, want);
      errors++;
    endtask

    task check_status(logic [OutDataW-1:0] got);
      status_t want;
      if (pending_status.size() == 0) begin
        report_mismatch("status beat with no command pending", got, '0);
        return;
      end
      want = pending_status.pop_front();
      if (got[2:0] !== want.chosen_index)
        report_mismatch("chosen_index", OutDataW'(got[2:0]),
                        OutDataW'(want.chosen_index));
      if (got[3] !== want.chosen_valid)
        report_mismatch("chosen_valid", OutDataW'(got[3]),
                        OutDataW'(want.chosen_valid));
      if (got[6:4] !== want.running_index)
        report_mismatch("running_index", OutDataW'(got[6:4]),
                        OutDataW'(want.running_index));
      if (got[7] !== want.running_valid)
        report_mismatch("running_valid", OutDataW'(got[7]),
                        OutDataW'(want.running_valid));
      if (got[39:8] !== want.tick_total)
        report_mismatch("tick_total", OutDataW'(got[39:8]),
                        OutDataW'(want.tick_total));
      if (got[43:40] !== want.task_total)
        report_mismatch("task_total", OutDataW'(got[43:40]),
                        OutDataW'(want.task_total));
      if (got[44] !== want.table_full_error)
        report_mismatch("table_full_error", OutDataW'(got[44]),
                        OutDataW'(want.table_full_error));
      if (got[47:45] !== 3'b000)
        report_mismatch("pad bits", OutDataW'(got[47:45]), '0);
      checked++;
    endtask
  endclass

  task_table_scoreboard sb = new();

  // opening sequence: empty-table corner cases, duplicate ids, no-match
  // disable, a lap with nothing ready, then fill-up further below
  op_e            lead_ops [20] = '{
    OP_TICK, OP_START, OP_SWITCH, OP_BLOCK, OP_RESUME, OP_ENABLE,
    OP_CREATE, OP_CREATE, OP_CREATE,
    OP_DISABLE, OP_DISABLE, OP_DISABLE,
    OP_TICK, OP_START, OP_SWITCH, OP_BLOCK, OP_TICK, OP_RESUME, OP_SWITCH, OP_ENABLE
  };
  logic [IdW-1:0] lead_ids [20] = '{
    '0, '0, '0, '0, '0, 32'd5,
    32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0000,
    32'h0000_0000, 32'hFFFF_FFFF, 32'h1234_5678,
    '0, '0, '0, '0, '0, '0, '0, 32'hFFFF_FFFF
  };

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Offer one command and hold it until accepted; then maybe drop tvalid
  // for a short burst.
  task automatic send_command(op_e op, logic [IdW-1:0] id, bit may_idle);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= id;
    s_axis_tuser  <= op;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_command(op, id);
    if (may_idle && $urandom_range(0, 4) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
  endtask

  task automatic wait_for_drain();
    s_axis_tvalid <= 1'b0;
    while (sb.pending_status.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic [IdW-1:0] pick_known_id();
    if (sb.count == 0 || $urandom_range(0, 3) == 0) return $urandom();
    return sb.ids[$urandom_range(0, sb.count - 1)];
  endfunction

  initial begin : command_source
    op_e            op;
    logic [IdW-1:0] id;
    int unsigned    r;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= OP_CREATE;
    hold_asks     <= 0;
    quiet_end     <= 1'b0;
    rst_ni        <= 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (lead_ops[k]) begin
      op = lead_ops[k];
      id = (op == OP_CREATE || op == OP_DISABLE || op == OP_ENABLE) ? lead_ids[k] : $urandom();
      send_command(op, id, 1'b1);
    end
    // fill the table, then one refused create
    while (sb.count < Slots) send_command(OP_CREATE, $urandom(), 1'b1);
    send_command(OP_CREATE, $urandom(), 1'b1);

    for (int unsigned n = 0; n < RandomItems; n++) begin
      if (n == HoldAtItem) hold_asks <= hold_asks + 1;
      if (n == DrainAtItem) wait_for_drain();
      if (n == RandomItems - QuietItems) quiet_end <= 1'b1;
      r = $urandom_range(0, 99);
      if      (r < 4)  op = OP_CREATE;
      else if (r < 14) op = OP_DISABLE;
      else if (r < 28) op = OP_ENABLE;
      else if (r < 52) op = OP_TICK;
      else if (r < 68) op = OP_SWITCH;
      else if (r < 78) op = OP_START;
      else if (r < 89) op = OP_BLOCK;
      else             op = OP_RESUME;
      id = (op == OP_DISABLE || op == OP_ENABLE) ? pick_known_id() : $urandom();
      send_command(op, id, n < RandomItems - QuietItems);
    end

    wait_for_drain();
    repeat (SettleCycles) @(posedge clk_i);
    if (sb.pending_status.size() != 0)
      sb.report_mismatch("status beats never returned",
                         OutDataW'(sb.pending_status.size()), '0);

    $display("Covered %0d status beats: create %0d, disable %0d, enable %0d, tick %0d,",
             sb.checked, sb.op_seen[OP_CREATE], sb.op_seen[OP_DISABLE],
             sb.op_seen[OP_ENABLE], sb.op_seen[OP_TICK]);
    $display("  switch %0d, start %0d, block %0d, resume %0d; sink and source stalls mixed in",
             sb.op_seen[OP_SWITCH], sb.op_seen[OP_START], sb.op_seen[OP_BLOCK],
             sb.op_seen[OP_RESUME]);
    if (sb.errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // Status sink: random short stalls, one long hold-off on request, none at the end.
  initial begin : status_sink
    int unsigned stall_left;
    int unsigned hold_seen;
    stall_left = 0;
    hold_seen  = 0;
    m_axis_tready <= 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid && m_axis_tready) sb.check_status(m_axis_tdata);
      if (hold_seen != hold_asks) begin
        hold_seen  = hold_asks;
        stall_left = LongHoldCycles;
      end else if (stall_left == 0 && !quiet_end && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 3);
      end
      if (stall_left != 0) begin
        stall_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Ends the run if no beat moves on either stream for too long.
  initial begin : watchdog
    int unsigned idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < WatchdogLimit) begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("Timeout: no beat moved for %0d cycles", WatchdogLimit);
    $display("Verification failed");
    $finish;
  end

endmodule
